// ----- rtl/esort_pkg.sv -----
// Shared types and constants for the exchange sort engine.
// No dependencies; the controller, datapath and top level import this package.
`timescale 1ns / 1ps

package esort_pkg;

   // Default buffer depth and element width.
   localparam int DEPTH_DEF = 64;
   localparam int VALUE_W   = 32;

   // Per-cycle command from the controller to the datapath.
   typedef struct packed {
      logic rd_en;    // read the element store at rd_addr
      logic load_a;   // capture read data into the held element
      logic cmp_en;   // compare the held element with read data and swap if smaller
      logic wr_load;  // write the incoming request value at wr_addr
      logic wr_a;     // write the held element back at wr_addr
   } esort_cmd_type;

endpackage

// ----- rtl/esort_dp.sv -----
// Datapath of the exchange sort engine: element store, held element and compare-swap.
// Depends on esort_pkg; driven by esort_ctrl through esort_cmd_type commands.
`timescale 1ns / 1ps

module esort_dp
   import esort_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  logic                       clock,
   input  esort_cmd_type              cmd,
   input  logic [IDX_W-1:0]           rd_addr,
   input  logic [IDX_W-1:0]           wr_addr,
   input  logic signed [VALUE_W-1:0]  req_value,
   output logic signed [VALUE_W-1:0]  rsp_sorted_value
);

   logic signed [VALUE_W-1:0] store_ff [DEPTH];
   logic signed [VALUE_W-1:0] rdata_ff;
   logic signed [VALUE_W-1:0] a_ff;
   logic signed [VALUE_W-1:0] a_in;
   logic signed [VALUE_W-1:0] wdata;
   logic                      swap;
   logic                      we;

   // The held element (entry i) swaps with entry j when it is the smaller one.
   assign swap  = cmd.cmp_en && (a_ff < rdata_ff);
   assign we    = cmd.wr_load || cmd.wr_a || swap;
   assign wdata = cmd.wr_load ? req_value : a_ff;

   // The held element takes the read data on a load or on a swap.
   always_comb begin
      a_in = a_ff;
      if (cmd.load_a || swap) begin
         a_in = rdata_ff;
      end
   end

   // Element store with one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[wr_addr] <= wdata;
      end
      if (cmd.rd_en) begin
         rdata_ff <= store_ff[rd_addr];
      end
   end

   // Held element register.
   always_ff @(posedge clock) begin
      a_ff <= a_in;
   end

   // Read data is held while no read is issued, so it serves as the output register.
   assign rsp_sorted_value = rdata_ff;

endmodule

// ----- rtl/esort_ctrl.sv -----
// Controller of the exchange sort engine: load, sort passes and output sequencing.
// Depends on esort_pkg; issues esort_cmd_type commands to esort_dp.
`timescale 1ns / 1ps

module esort_ctrl
   import esort_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF,
   localparam int IDX_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_last_item,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_last_result,
   output logic              rsp_overflow,
   output esort_cmd_type     cmd,
   output logic [IDX_W-1:0]  rd_addr,
   output logic [IDX_W-1:0]  wr_addr
);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_AREAD = 3'd1;
   localparam logic [2:0] S_ALOAD = 3'd2;
   localparam logic [2:0] S_SCAN  = 3'd3;
   localparam logic [2:0] S_AWRITE = 3'd4;
   localparam logic [2:0] S_ORD   = 3'd5;
   localparam logic [2:0] S_OSHOW = 3'd6;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             dropped_ff, dropped_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0] j_ff, j_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pidx_ff, pidx_in;
   logic [CNT_W-1:0] count_m1;
   logic [IDX_W-1:0] last_idx;

   // Index of the last stored element; only used while the set is non-empty.
   assign count_m1 = count_ff - CNT_W'(1);
   assign last_idx = count_m1[IDX_W-1:0];

   // Next-state and command logic.
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      dropped_in = dropped_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      pend_in    = pend_ff;
      pidx_in    = pidx_ff;
      cmd        = '0;
      rd_addr    = '0;
      wr_addr    = '0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (count_ff < DEPTH_CNT) begin
                  cmd.wr_load = 1'b1;
                  wr_addr     = count_ff[IDX_W-1:0];
                  count_in    = count_ff + CNT_W'(1);
               end else begin
                  dropped_in = 1'b1;
               end
               if (req_last_item) begin
                  i_in     = '0;
                  state_in = S_AREAD;
               end
            end
         end
         S_AREAD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = i_ff;
            state_in  = S_ALOAD;
         end
         S_ALOAD: begin
            // Capture entry i and start the inner pass with entry zero.
            cmd.load_a = 1'b1;
            cmd.rd_en  = 1'b1;
            rd_addr    = '0;
            pend_in    = 1'b1;
            pidx_in    = '0;
            j_in       = CNT_W'(1);
            state_in   = S_SCAN;
         end
         S_SCAN: begin
            // Compare the pending entry; entry i itself never swaps with itself.
            cmd.cmp_en = pend_ff && (pidx_ff != i_ff);
            wr_addr    = pidx_ff;
            if (j_ff < count_ff) begin
               cmd.rd_en = 1'b1;
               rd_addr   = j_ff[IDX_W-1:0];
               pend_in   = 1'b1;
               pidx_in   = j_ff[IDX_W-1:0];
               j_in      = j_ff + CNT_W'(1);
            end else begin
               pend_in = 1'b0;
            end
            if (!pend_ff) begin
               state_in = S_AWRITE;
            end
         end
         S_AWRITE: begin
            cmd.wr_a = 1'b1;
            wr_addr  = i_ff;
            if (i_ff == last_idx) begin
               k_in     = '0;
               state_in = S_ORD;
            end else begin
               i_in     = i_ff + IDX_W'(1);
               state_in = S_AREAD;
            end
         end
         S_ORD: begin
            cmd.rd_en = 1'b1;
            rd_addr   = k_ff;
            state_in  = S_OSHOW;
         end
         S_OSHOW: begin
            if (!rsp_stall) begin
               if (k_ff == last_idx) begin
                  count_in   = '0;
                  dropped_in = 1'b0;
                  state_in   = S_LOAD;
               end else begin
                  k_in     = k_ff + IDX_W'(1);
                  state_in = S_ORD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_LOAD;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
         pend_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
         pend_ff    <= pend_in;
      end
   end

   // Loop indexes.
   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      j_ff    <= j_in;
      k_ff    <= k_in;
      pidx_ff <= pidx_in;
   end

   // Handshake and result flags.
   assign req_stall       = (state_ff != S_LOAD);
   assign rsp_valid       = (state_ff == S_OSHOW);
   assign rsp_last_result = (k_ff == last_idx);
   assign rsp_overflow    = dropped_ff;

`ifndef SYNTHESIS
   // The fill count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("element count above depth");

   // A pending compare always refers to a stored entry.
   a_pend_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) && pend_ff |-> (CNT_W'(pidx_ff) < count_ff))
      else $error("compare index outside the stored set");

   // A request marked last starts the sort.
   a_last_starts_sort: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last_item |=> (state_ff == S_AREAD))
      else $error("last request did not start the sort");

   // Taking the final result empties the engine.
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_last_result |=>
         (state_ff == S_LOAD) && (count_ff == '0) && !dropped_ff)
      else $error("engine not empty after final result");
`endif

endmodule

// ----- rtl/exchange_sort_engine.sv -----
// Loading: one request per cycle while req_stall is low; a set of n entries is then sorted in place.
// Output: each sorted result is read from the store, then presented and held through any stall.
// Requests stall from the last item of a set until its final result is taken; the element store
// has a single read port.
// Reset: synchronous, active high; clears the fill count, overflow flag and sequencer.
// Top level of the exchange sort engine; depends on esort_pkg, esort_ctrl and esort_dp.
`timescale 1ns / 1ps

module exchange_sort_engine
   import esort_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [VALUE_W-1:0]  req_value,
   input  logic                       req_last_item,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [VALUE_W-1:0]  rsp_sorted_value,
   output logic                       rsp_last_result,
   output logic                       rsp_overflow
);

   localparam int IDX_W = $clog2(DEPTH);

   esort_cmd_type    cmd;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;

   // Sequencer for load, sort passes and output.
   esort_ctrl #(
      .DEPTH(DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_last_item   (req_last_item),
      .req_stall       (req_stall),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_last_result (rsp_last_result),
      .rsp_overflow    (rsp_overflow),
      .cmd             (cmd),
      .rd_addr         (rd_addr),
      .wr_addr         (wr_addr)
   );

   // Element store and compare-swap unit.
   esort_dp #(
      .DEPTH(DEPTH)
   ) u_dp (
      .clock            (clock),
      .cmd              (cmd),
      .rd_addr          (rd_addr),
      .wr_addr          (wr_addr),
      .req_value        (req_value),
      .rsp_sorted_value (rsp_sorted_value)
   );

endmodule

// ----- tb/sv/tb_exchange_sort_engine.sv -----
// Self-checking testbench for exchange_sort_engine: sends sets of signed values and checks
// that every set comes back in ascending order with the right last and overflow flags.
// Depends on esort_pkg and the exchange_sort_engine RTL.
`timescale 1ns / 1ps

module tb_exchange_sort_engine
   import esort_pkg::*;
();

   localparam int CYCLE_LIMIT = 400000;
   localparam int TARGET_ITEMS = 350;

   // One expected result of a sorted set.
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      last;
      logic                      overflow;
   } sorted_entry_type;

   // How the values of a random set are chosen.
   typedef enum int {
      FILL_WIDE,
      FILL_NARROW,
      FILL_EXTREME
   } fill_mode_type;

   // Holds the predicted contents of the buffer and the results still owed by the block.
   class sort_scoreboard_type;
      logic signed [VALUE_W-1:0] held_values [DEPTH_DEF];
      int unsigned               held_count;
      bit                        dropped;
      sorted_entry_type          sorted_q [$];
      int unsigned               error_count;

      function new();
         held_count  = 0;
         dropped     = 1'b0;
         error_count = 0;
      endfunction

      function int pending();
         return sorted_q.size();
      endfunction

      // Stores an accepted request and, on the final one of a set, predicts the sorted output.
      function void note_request(logic signed [VALUE_W-1:0] value, logic last_item);
         int                        i;
         int                        j;
         logic signed [VALUE_W-1:0] key;
         sorted_entry_type          entry;
         if (held_count < DEPTH_DEF) begin
            held_values[held_count] = value;
            held_count++;
         end else begin
            dropped = 1'b1;
         end
         if (!last_item) return;
         // Insertion sort on the signed values gives the same ascending order.
         for (i = 1; i < held_count; i++) begin
            key = held_values[i];
            j = i - 1;
            while (j >= 0 && held_values[j] > key) begin
               held_values[j + 1] = held_values[j];
               j--;
            end
            held_values[j + 1] = key;
         end
         for (i = 0; i < held_count; i++) begin
            entry.value    = held_values[i];
            entry.last     = (i == held_count - 1);
            entry.overflow = dropped;
            sorted_q.push_back(entry);
         end
         held_count = 0;
         dropped    = 1'b0;
      endfunction

      task report_mismatch(string what);
         $display("MISMATCH at %0t: %s", $time, what);
         error_count++;
      endtask

      // Compares one accepted result with the oldest expectation.
      task check_result(logic signed [VALUE_W-1:0] value, logic last_result, logic overflow);
         sorted_entry_type want;
         if (sorted_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result value %0d", value));
            return;
         end
         want = sorted_q.pop_front();
         if (value !== want.value)
            report_mismatch($sformatf("sorted_value %0d, expected %0d", value, want.value));
         if (last_result !== want.last)
            report_mismatch($sformatf("last_result %0b, expected %0b", last_result, want.last));
         if (overflow !== want.overflow)
            report_mismatch($sformatf("overflow %0b, expected %0b", overflow, want.overflow));
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      req_last_item = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic signed [VALUE_W-1:0] rsp_sorted_value;
   logic                      rsp_last_result;
   logic                      rsp_overflow;

   sort_scoreboard_type       sb;
   logic signed [VALUE_W-1:0] set_q [$];
   int                        items_sent = 0;
   int                        cycle_count = 0;
   int                        stall_left = 0;
   bit                        quiet_mode = 1'b0;

   exchange_sort_engine #(
      .DEPTH(DEPTH_DEF)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_value       (req_value),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_sorted_value(rsp_sorted_value),
      .rsp_last_result (rsp_last_result),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Idle length: mostly none or short, now and then long, never in a quiet stretch.
   function int pick_gap();
      int roll;
      if (quiet_mode) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one request and holds it until the block takes it.
   task send_request(logic signed [VALUE_W-1:0] value, logic last_item);
      req_valid     <= 1'b1;
      req_value     <= value;
      req_last_item <= last_item;
      do @(posedge clock); while (req_stall);
      sb.note_request(value, last_item);
      items_sent++;
   endtask

   // Sends the values in set_q with random gaps, marking the final one as last.
   task send_set();
      int k;
      int gap;
      for (k = 0; k < set_q.size(); k++) begin
         gap = pick_gap();
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         send_request(set_q[k], k == set_q.size() - 1);
      end
   endtask

   // Holds off the sender until the block has returned every owed result.
   task wait_for_drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task build_random_set(int size);
      fill_mode_type mode;
      int            k;
      mode = fill_mode_type'($urandom_range(0, 2));
      set_q.delete();
      for (k = 0; k < size; k++) begin
         case (mode)
            FILL_WIDE: begin
               set_q.push_back($urandom);
            end
            FILL_NARROW: begin
               set_q.push_back(int'($urandom_range(0, 8)) - 4);
            end
            default: begin
               case ($urandom_range(0, 4))
                  0: set_q.push_back(32'sh7fff_ffff);
                  1: set_q.push_back(32'sh8000_0000);
                  2: set_q.push_back(32'sd0);
                  3: set_q.push_back(-32'sd1);
                  default: set_q.push_back(32'sd1);
               endcase
            end
         endcase
      end
   endtask

   // Result side: check each accepted result and stall at random.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_sorted_value, rsp_last_result, rsp_overflow);
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         stall_left = pick_gap();
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int set_num;
      int size;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed sets: a single element, the extremes with repeats, all equal,
      // descending input and input that is already in order.
      set_q = '{32'sh7fff_ffff};
      send_set();
      set_q = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, -32'sd1, 32'sd1,
                32'sh8000_0000, 32'sh7fff_ffff, 32'sh4000_0000, -32'sd2};
      send_set();
      set_q = '{32'sd5, 32'sd5, 32'sd5};
      send_set();
      set_q = '{32'sd3, 32'sd2, 32'sd1, 32'sd0, -32'sd1, -32'sd2};
      send_set();
      set_q = '{-32'sd3, -32'sd2, -32'sd1};
      send_set();
      wait_for_drain();

      // Random sets; a full buffer, an overflow whose last request is dropped,
      // and a larger overflow are placed among mostly small sets.
      set_num = 0;
      while (items_sent < TARGET_ITEMS) begin
         if (set_num == 2)
            size = DEPTH_DEF;
         else if (set_num == 6)
            size = DEPTH_DEF + 1;
         else if (set_num == 11)
            size = $urandom_range(DEPTH_DEF + 2, DEPTH_DEF + 8);
         else if ($urandom_range(0, 9) == 0)
            size = $urandom_range(13, 40);
         else
            size = $urandom_range(1, 12);
         quiet_mode = ($urandom_range(0, 3) == 0);
         if (set_num == 8) wait_for_drain();
         build_random_set(size);
         send_set();
         set_num++;
      end

      // Let the last set come back, then a short settle.
      quiet_mode = 1'b0;
      wait_for_drain();
      repeat (50) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
